### hw/rtl/adc_noise_random_byte_mixer_defines.svh
// assertion macros used by the checker file of the random byte mixer
`ifndef ADC_NOISE_RANDOM_BYTE_MIXER_DEFINES_SVH
`define ADC_NOISE_RANDOM_BYTE_MIXER_DEFINES_SVH

// same-cycle implication, quiet during reset
`define ANRBM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, quiet during reset
`define ANRBM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("%m: check failed");

// next-cycle implication that also holds across reset
`define ANRBM_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

### hw/rtl/anrbm_pkg.sv
// shared types and constants of the random byte mixer
`default_nettype none

package anrbm_pkg;

    // last pair of a byte
    localparam logic [1:0] LastPair = 2'd3;

    // running mixer state
    typedef struct packed {
        logic [7:0] left_mix;
        logic [7:0] right_mix;
        logic [7:0] prev_mix;
        logic [7:0] acc;
        logic [1:0] pair_index;
        logic       stack_choice;
    } mix_state_t;

endpackage

`default_nettype wire

### hw/rtl/anrbm_mix.sv
// combinational next-state and output function for one sample pair
`default_nettype none

module anrbm_mix (
    input  wire anrbm_pkg::mix_state_t state_i,
    input  wire logic [7:0]            left_i,
    input  wire logic [7:0]            right_i,
    output anrbm_pkg::mix_state_t      state_o,
    output logic [7:0]                 byte_o,
    output logic                       last_o
);

    // rotate an 8-bit value left by n
    function automatic logic [7:0] rotl8(input logic [7:0] v, input logic [2:0] n);
        logic [15:0] w;
        w = {v, v} << n;
        return w[15:8];
    endfunction

    logic [2:0] rot_l;
    logic [2:0] rot_r;
    logic       choice;
    logic [7:0] acc;
    logic [7:0] lm;
    logic [7:0] rm;
    logic [7:0] m;

    assign rot_l  = {1'b0, state_i.pair_index};
    assign rot_r  = 3'd7 - {1'b0, state_i.pair_index};
    assign last_o = (state_i.pair_index == anrbm_pkg::LastPair);

    // stack choice is latched at the first pair of a byte
    assign choice = (state_i.pair_index == 2'd0) ?
                    (state_i.left_mix[0] ^ state_i.right_mix[0]) : state_i.stack_choice;

    // accumulate rotated samples
    assign acc = state_i.acc ^ rotl8(left_i, rot_l) ^ rotl8(right_i, rot_r);

    // fold left bits into the chosen stack wherever the samples differ
    always_comb begin
        lm = state_i.left_mix;
        rm = state_i.right_mix;
        for (int j = 0; j < 8; j++) begin
            if (left_i[j] != right_i[j]) begin
                if (!choice) begin
                    lm = (lm << 1) ^ {7'd0, left_i[j]} ^ lm;
                end else begin
                    rm = (rm >> 1) ^ {left_i[j], 7'd0} ^ rm;
                end
            end
        end
    end

    // output mix at end of byte
    assign m = state_i.prev_mix ^ (state_i.prev_mix >> 3) ^ (state_i.prev_mix << 5)
             ^ (state_i.prev_mix >> 4) ^ acc;
    assign byte_o = m ^ lm ^ rm;

    // next state
    always_comb begin
        state_o.left_mix     = lm;
        state_o.right_mix    = rm;
        state_o.stack_choice = choice;
        if (last_o) begin
            state_o.prev_mix   = m;
            state_o.acc        = 8'd0;
            state_o.pair_index = 2'd0;
        end else begin
            state_o.prev_mix   = state_i.prev_mix;
            state_o.acc        = acc;
            state_o.pair_index = state_i.pair_index + 2'd1;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/adc_noise_random_byte_mixer.sv
// The fourth sample pair of a byte passes the input register; the byte is then held in the output register.
// Throughput: one pair per cycle unless a fourth pair waits on an output byte not yet taken; the input
// register feeds the mix logic and the output register, which drains while the next pair is taken.
// Pairs one to three give no item; every fourth pair gives one byte.
// Reset (aresetn low, synchronous) clears all mix state and both valid flags.
`default_nettype none

module adc_noise_random_byte_mixer (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [9:0] s_left_sample,
    input  wire logic [9:0] s_right_sample,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_random_byte
);

    logic                  in_valid_reg;
    logic [7:0]            in_left_reg;
    logic [7:0]            in_right_reg;
    anrbm_pkg::mix_state_t state_reg;
    anrbm_pkg::mix_state_t state_next;
    logic                  out_valid_reg;
    logic [7:0]            out_byte_reg;
    logic [7:0]            byte_next;
    logic                  last;
    logic                  out_free;
    logic                  advance;

    anrbm_mix u_mix (
        .state_i (state_reg),
        .left_i  (in_left_reg),
        .right_i (in_right_reg),
        .state_o (state_next),
        .byte_o  (byte_next),
        .last_o  (last)
    );

    // handshake control
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!last || out_free);
    assign s_ready  = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_left_reg  <= s_left_sample[7:0];
            in_right_reg <= s_right_sample[7:0];
        end
    end

    // mix state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && last) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && last) begin
            out_byte_reg <= byte_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_random_byte = out_byte_reg;

endmodule

`default_nettype wire

### hw/rtl/anrbm_checker.sv
// port-level checks of the random byte mixer and their bind
`default_nettype none
`include "adc_noise_random_byte_mixer_defines.svh"

module anrbm_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_random_byte
);

    logic [1:0] pair_cnt_reg;
    logic [1:0] pair_cnt_next;
    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       s_acc;
    logic       m_acc;
    logic       byte_done;

    assign s_acc     = s_valid && s_ready;
    assign m_acc     = m_valid && m_ready;
    assign byte_done = s_acc && (pair_cnt_reg == anrbm_pkg::LastPair);

    // count pairs and bytes owed on the output
    always_comb begin
        pair_cnt_next = s_acc ? pair_cnt_reg + 2'd1 : pair_cnt_reg;
        pending_next  = pending_reg + {1'b0, byte_done} - {1'b0, m_acc};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_cnt_reg <= 2'd0;
            pending_reg  <= 2'd0;
        end else begin
            pair_cnt_reg <= pair_cnt_next;
            pending_reg  <= pending_next;
        end
    end

    `ANRBM_ASSERT_RST(a_reset_clears_out, !aresetn, !m_valid)
    `ANRBM_ASSERT_NEXT(a_out_holds, m_valid && !m_ready, m_valid && $stable(m_random_byte))
    `ANRBM_ASSERT_NOW(a_no_extra_byte, m_valid, pending_reg != 2'd0)
    `ANRBM_ASSERT_NOW(a_pending_bounded, 1'b1, pending_reg != 2'd3)

endmodule

bind adc_noise_random_byte_mixer anrbm_checker u_anrbm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_random_byte (m_random_byte)
);

`default_nettype wire
